[hdl/ffrs_pkg.sv]
// shared types and constants of the first-fit room and slot assigner
package ffrs_pkg;

    // function codes of an input beat
    localparam logic [1:0] FUNC_SET_CAP   = 2'd0;
    localparam logic [1:0] FUNC_ADD_PAIR  = 2'd1;
    localparam logic [1:0] FUNC_BEGIN     = 2'd2;
    localparam logic [1:0] FUNC_PLACE     = 2'd3;

    // configuration register indexes
    localparam logic CFG_NUM_ROOMS = 1'b0;
    localparam logic CFG_SLOT_CAP  = 1'b1;

    localparam int CFG_WIDTH     = 11;
    localparam int BITS_PER_WORD = 64;

    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  course_id;
        logic [9:0]  partner_course;
        logic [3:0]  room_index;
        logic [15:0] amount;
    } in_beat_t;

    typedef struct packed {
        logic        placed;
        logic [10:0] assigned_slot;
        logic [4:0]  assigned_room;
        logic [10:0] highest_used_slot;
    } out_beat_t;

endpackage

[hdl/first_fit_room_slot_assigner.sv]
// first-fit room and slot assigner: top level with sequencer and memories
//
// Usage: beats enter on s_valid/s_ready/s_data and one result beat leaves on
// m_valid/m_ready/m_data for every input beat. Configuration (num_rooms,
// slot_cap) is written through cfg_we/cfg_index/cfg_wdata; the user must do
// so only while idle, which the block itself does not enforce.
// A place beat walks rooms in order and, in each room whose capacity fits,
// slots in order; each slot checks its WORDS = ceil(MAX_COURSES/64) conflict
// words one at a time (one registered memory read, then one compare) through
// the single conflict compare unit.
// A begin-pass beat sweeps the slot members and occupancy memories.
// After reset the same sweep also clears the conflict matrix, and s_ready
// stays low until the sweep ends; configuration writes are taken meanwhile.
// A finished result sits in an output register; the next input beat is
// accepted while it waits, and its own result is held until m_ready.
module first_fit_room_slot_assigner #(
    parameter int MAX_COURSES = 1024,
    parameter int MAX_ROOMS   = 16,
    parameter int MAX_SLOTS   = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ffrs_pkg::in_beat_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ffrs_pkg::out_beat_t           m_data,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ffrs_pkg::CFG_WIDTH-1:0] cfg_wdata
);

    localparam int WORDS = (MAX_COURSES + 63) / 64;
    localparam int CW    = $clog2(MAX_COURSES);
    localparam int XW    = (CW > 10) ? CW : 10;
    localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CMD   = MAX_COURSES * WORDS;
    localparam int SMD   = MAX_SLOTS * WORDS;
    localparam int BD    = MAX_ROOMS * MAX_SLOTS;
    localparam int CMAW  = $clog2(CMD);
    localparam int SMAW  = $clog2(SMD);
    localparam int BAW   = $clog2(BD);
    localparam int CLD0  = (CMD > SMD) ? CMD : SMD;
    localparam int CLD   = (CLD0 > BD) ? CLD0 : BD;
    localparam int CLAW  = $clog2(CLD + 1);
    localparam int RCW   = $clog2(MAX_ROOMS + 1);
    localparam int RIW   = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int SCW   = $clog2(MAX_SLOTS + 1);
    localparam int BW    = ffrs_pkg::BITS_PER_WORD;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_CLEAR   = 10'b0000000010,
        ST_PAIR_RD = 10'b0000000100,
        ST_PAIR_WR = 10'b0000001000,
        ST_ROOM    = 10'b0000010000,
        ST_SLOT    = 10'b0000100000,
        ST_ISSUE   = 10'b0001000000,
        ST_CHECK   = 10'b0010000000,
        ST_COMMIT  = 10'b0100000000,
        ST_RESP    = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    ffrs_pkg::in_beat_t  item_reg, item_next;
    ffrs_pkg::out_beat_t m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;
    logic [4:0]          num_rooms_reg, num_rooms_next;
    logic [10:0]         slot_cap_reg, slot_cap_next;
    logic [CLAW-1:0]     clr_reg, clr_next;
    logic                clr_cm_reg, clr_cm_next;
    logic                phase_reg, phase_next;
    logic [RCW-1:0]      r_reg, r_next;
    logic [SCW-1:0]      s_reg, s_next;
    logic [WIW-1:0]      w_reg, w_next;
    logic [SCW-1:0]      max_reg, max_next;
    logic [BW-1:0]       keep_reg, keep_next;
    logic                res_placed_reg, res_placed_next;
    logic [10:0]         res_slot_reg, res_slot_next;
    logic [4:0]          res_room_reg, res_room_next;

    logic [15:0]         cap_mem [MAX_ROOMS];
    logic                cap_we;

    logic [BW-1:0]       cm_mem [CMD];
    logic [BW-1:0]       cm_rdata, cm_wdata;
    logic [CMAW-1:0]     cm_raddr, cm_waddr;
    logic                cm_we;

    logic [BW-1:0]       sm_mem [SMD];
    logic [BW-1:0]       sm_rdata, sm_wdata;
    logic [SMAW-1:0]     sm_raddr, sm_waddr;
    logic                sm_we;

    logic                busy_mem [BD];
    logic                busy_rdata, busy_wdata;
    logic [BAW-1:0]      busy_addr;
    logic                busy_we;

    // derived item fields
    logic [XW-1:0]       course_x, partner_x, row_x, col_x;
    logic [WIW-1:0]      cword;
    logic [CMAW-1:0]     pair_addr;
    logic [5:0]          pair_bit;
    logic [RCW-1:0]      rooms_lim;
    logic [SCW-1:0]      slots_lim;
    logic [SCW-1:0]      s_plus;

    assign course_x  = XW'(item_reg.course_id);
    assign partner_x = XW'(item_reg.partner_course);
    assign cword     = WIW'(course_x >> 6);
    assign row_x     = phase_reg ? partner_x : course_x;
    assign col_x     = phase_reg ? course_x : partner_x;
    assign pair_bit  = phase_reg ? item_reg.course_id[5:0] : item_reg.partner_course[5:0];
    assign pair_addr = CMAW'(row_x[CW-1:0]) * CMAW'(WORDS) + CMAW'(col_x >> 6);
    assign rooms_lim = (32'(num_rooms_reg) < 32'(MAX_ROOMS)) ? RCW'(num_rooms_reg)
                                                             : RCW'(MAX_ROOMS);
    assign slots_lim = (32'(slot_cap_reg) < 32'(MAX_SLOTS)) ? SCW'(slot_cap_reg)
                                                            : SCW'(MAX_SLOTS);
    assign s_plus    = s_reg + SCW'(1);

    // memory addressing
    always_comb begin
        cm_raddr  = (state_reg == ST_PAIR_RD) ? pair_addr
                  : CMAW'(course_x[CW-1:0]) * CMAW'(WORDS) + CMAW'(w_reg);
        sm_raddr  = SMAW'(s_reg) * SMAW'(WORDS) + SMAW'(w_reg);
        cm_we     = 1'b0;
        cm_waddr  = pair_addr;
        cm_wdata  = cm_rdata | (BW'(1) << pair_bit);
        sm_we     = 1'b0;
        sm_waddr  = SMAW'(s_reg) * SMAW'(WORDS) + SMAW'(cword);
        sm_wdata  = keep_reg | (BW'(1) << item_reg.course_id[5:0]);
        busy_we   = 1'b0;
        busy_addr = BAW'(r_reg) * BAW'(MAX_SLOTS) + BAW'(s_reg);
        busy_wdata = 1'b1;
        if (state_reg == ST_CLEAR) begin
            cm_we      = clr_cm_reg && (32'(clr_reg) < 32'(CMD));
            cm_waddr   = CMAW'(clr_reg);
            cm_wdata   = '0;
            sm_we      = 32'(clr_reg) < 32'(SMD);
            sm_waddr   = SMAW'(clr_reg);
            sm_wdata   = '0;
            busy_we    = 32'(clr_reg) < 32'(BD);
            busy_addr  = BAW'(clr_reg);
            busy_wdata = 1'b0;
        end else if (state_reg == ST_PAIR_WR) begin
            cm_we = 1'b1;
        end else if (state_reg == ST_COMMIT) begin
            sm_we   = 1'b1;
            busy_we = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        num_rooms_next  = num_rooms_reg;
        slot_cap_next   = slot_cap_reg;
        clr_next        = clr_reg;
        clr_cm_next     = clr_cm_reg;
        phase_next      = phase_reg;
        r_next          = r_reg;
        s_next          = s_reg;
        w_next          = w_reg;
        max_next        = max_reg;
        keep_next       = keep_reg;
        res_placed_next = res_placed_reg;
        res_slot_next   = res_slot_reg;
        res_room_next   = res_room_reg;
        cap_we          = 1'b0;

        // configuration writes
        if (cfg_we) begin
            unique case (cfg_index)
                ffrs_pkg::CFG_NUM_ROOMS: num_rooms_next = cfg_wdata[4:0];
                ffrs_pkg::CFG_SLOT_CAP:  slot_cap_next  = cfg_wdata[10:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next       = s_data;
                    res_placed_next = 1'b1;
                    res_slot_next   = '0;
                    res_room_next   = '0;
                    phase_next      = 1'b0;
                    unique case (s_data.func)
                        ffrs_pkg::FUNC_SET_CAP: begin
                            cap_we     = 32'(s_data.room_index) < 32'(MAX_ROOMS);
                            state_next = ST_RESP;
                        end
                        ffrs_pkg::FUNC_ADD_PAIR: begin
                            if (32'(s_data.course_id) < 32'(MAX_COURSES) &&
                                32'(s_data.partner_course) < 32'(MAX_COURSES)) begin
                                state_next = ST_PAIR_RD;
                            end else begin
                                state_next = ST_RESP;
                            end
                        end
                        ffrs_pkg::FUNC_BEGIN: begin
                            clr_next    = '0;
                            clr_cm_next = 1'b0;
                            max_next    = '0;
                            state_next  = ST_CLEAR;
                        end
                        ffrs_pkg::FUNC_PLACE: begin
                            res_placed_next = 1'b0;
                            r_next          = '0;
                            state_next = (32'(s_data.course_id) < 32'(MAX_COURSES))
                                         ? ST_ROOM : ST_RESP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                clr_next = clr_reg + CLAW'(1);
                if (clr_reg == CLAW'(CLD - 1)) begin
                    state_next  = clr_cm_reg ? ST_IDLE : ST_RESP;
                    clr_cm_next = 1'b0;
                end
            end
            ST_PAIR_RD: begin
                state_next = ST_PAIR_WR;
            end
            ST_PAIR_WR: begin
                phase_next = 1'b1;
                state_next = phase_reg ? ST_RESP : ST_PAIR_RD;
            end
            ST_ROOM: begin
                if (r_reg >= rooms_lim) begin
                    state_next = ST_RESP;
                end else if (cap_mem[r_reg[RIW-1:0]] < item_reg.amount) begin
                    r_next = r_reg + RCW'(1);
                end else begin
                    s_next     = '0;
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT: begin
                if (s_reg >= slots_lim) begin
                    r_next     = r_reg + RCW'(1);
                    state_next = ST_ROOM;
                end else begin
                    w_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_reg == cword) begin
                    keep_next = sm_rdata;
                end
                if (busy_rdata || ((cm_rdata & sm_rdata) != '0)) begin
                    s_next     = s_plus;
                    state_next = ST_SLOT;
                end else if (w_reg == WIW'(WORDS - 1)) begin
                    state_next = ST_COMMIT;
                end else begin
                    w_next     = w_reg + WIW'(1);
                    state_next = ST_ISSUE;
                end
            end
            ST_COMMIT: begin
                if (s_plus > max_reg) begin
                    max_next = s_plus;
                end
                res_placed_next = 1'b1;
                res_slot_next   = 11'(s_plus);
                res_room_next   = 5'(r_reg) + 5'd1;
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                  = 1'b1;
                    m_data_next.placed            = res_placed_reg;
                    m_data_next.assigned_slot     = res_slot_reg;
                    m_data_next.assigned_room     = res_room_reg;
                    m_data_next.highest_used_slot = 11'(max_reg);
                    state_next                    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            m_valid_reg   <= 1'b0;
            num_rooms_reg <= 5'd16;
            slot_cap_reg  <= 11'd1024;
            clr_reg       <= '0;
            clr_cm_reg    <= 1'b1;
            max_reg       <= '0;
            phase_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            num_rooms_reg <= num_rooms_next;
            slot_cap_reg  <= slot_cap_next;
            clr_reg       <= clr_next;
            clr_cm_reg    <= clr_cm_next;
            max_reg       <= max_next;
            phase_reg     <= phase_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        m_data_reg     <= m_data_next;
        r_reg          <= r_next;
        s_reg          <= s_next;
        w_reg          <= w_next;
        keep_reg       <= keep_next;
        res_placed_reg <= res_placed_next;
        res_slot_reg   <= res_slot_next;
        res_room_reg   <= res_room_next;
    end

    // room capacity table
    always_ff @(posedge aclk) begin
        if (cap_we) begin
            cap_mem[RIW'(s_data.room_index)] <= s_data.amount;
        end
    end

    // conflict matrix
    always_ff @(posedge aclk) begin
        if (cm_we) begin
            cm_mem[cm_waddr] <= cm_wdata;
        end
        cm_rdata <= cm_mem[cm_raddr];
    end

    // slot members
    always_ff @(posedge aclk) begin
        if (sm_we) begin
            sm_mem[sm_waddr] <= sm_wdata;
        end
        sm_rdata <= sm_mem[sm_raddr];
    end

    // room and slot occupancy
    always_ff @(posedge aclk) begin
        if (busy_we) begin
            busy_mem[busy_addr] <= busy_wdata;
        end
        busy_rdata <= busy_mem[busy_addr];
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hdl/ffrs_checker.sv]
// port-level assertions for the first-fit room and slot assigner, with bind
module ffrs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input ffrs_pkg::out_beat_t m_data
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // a failed or acknowledge beat carries no slot and no room
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.assigned_room == 5'd0) |->
            (m_data.assigned_slot == 11'd0))
        else $error("slot given without room");

    // a not-placed beat carries no room
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.placed |-> (m_data.assigned_room == 5'd0))
        else $error("room given on failed placement");

    // a given slot lies within the highest used slot
    a_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.assigned_room != 5'd0) |->
            (m_data.placed && (m_data.assigned_slot != 11'd0) &&
             (m_data.assigned_slot <= m_data.highest_used_slot)))
        else $error("slot beyond highest used slot");

endmodule

bind first_fit_room_slot_assigner ffrs_checker u_ffrs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/tb_first_fit_room_slot_assigner.sv]
// self-checking testbench of the first-fit room and slot assigner
module tb_first_fit_room_slot_assigner;

    localparam int N_COURSES   = 1024;
    localparam int N_ROOMS     = 16;
    localparam int N_SLOTS     = 1024;
    localparam int CYCLE_LIMIT = 2000000;

    // placement predictor and queue of predicted result beats
    class placement_board;
        bit [15:0]           room_cap [N_ROOMS];
        bit [N_COURSES-1:0]  conflicts [N_COURSES];
        bit [N_SLOTS-1:0]    room_busy [N_ROOMS];
        bit [N_COURSES-1:0]  members [N_SLOTS];
        bit [10:0]           top_slot;
        bit [4:0]            num_rooms;
        bit [10:0]           slot_cap;
        ffrs_pkg::out_beat_t pending [$];
        int                  errors;
        int                  placed_cnt;
        int                  failed_cnt;

        function new();
            foreach (room_cap[i]) room_cap[i] = '0;
            foreach (conflicts[i]) conflicts[i] = '0;
            errors = 0;
            placed_cnt = 0;
            failed_cnt = 0;
            num_rooms = 5'd16;
            slot_cap = 11'd1024;
            clear_pass();
        endfunction

        function void clear_pass();
            foreach (room_busy[i]) room_busy[i] = '0;
            foreach (members[i]) members[i] = '0;
            top_slot = '0;
        endfunction

        function void set_reg(logic idx, bit [10:0] val);
            if (idx == ffrs_pkg::CFG_NUM_ROOMS) num_rooms = val[4:0];
            else slot_cap = val;
        endfunction

        // work out the result of one accepted input beat
        function void note_input(ffrs_pkg::in_beat_t b);
            ffrs_pkg::out_beat_t r;
            int rooms;
            int slots;
            bit done;
            r = '0;
            r.placed = 1'b1;
            case (b.func)
                ffrs_pkg::FUNC_SET_CAP: room_cap[b.room_index] = b.amount;
                ffrs_pkg::FUNC_ADD_PAIR: begin
                    conflicts[b.course_id][b.partner_course] = 1'b1;
                    conflicts[b.partner_course][b.course_id] = 1'b1;
                end
                ffrs_pkg::FUNC_BEGIN: clear_pass();
                default: begin
                    rooms = (num_rooms > N_ROOMS) ? N_ROOMS : num_rooms;
                    slots = (slot_cap > N_SLOTS) ? N_SLOTS : slot_cap;
                    done = 1'b0;
                    r.placed = 1'b0;
                    for (int rm = 0; rm < rooms && !done; rm++) begin
                        if (room_cap[rm] < b.amount) continue;
                        for (int s = 0; s < slots && !done; s++) begin
                            if (room_busy[rm][s]) continue;
                            if ((conflicts[b.course_id] & members[s]) != '0) continue;
                            room_busy[rm][s] = 1'b1;
                            members[s][b.course_id] = 1'b1;
                            if (s + 1 > top_slot) top_slot = 11'(s + 1);
                            r.placed = 1'b1;
                            r.assigned_slot = 11'(s + 1);
                            r.assigned_room = 5'(rm + 1);
                            done = 1'b1;
                        end
                    end
                    if (done) placed_cnt++;
                    else failed_cnt++;
                end
            endcase
            r.highest_used_slot = top_slot;
            pending.push_back(r);
        endfunction

        // compare one result beat with the oldest prediction
        function void check(ffrs_pkg::out_beat_t got);
            ffrs_pkg::out_beat_t exp_b;
            if (pending.size() == 0) begin
                $error("result beat with nothing predicted: %h", got);
                errors++;
                return;
            end
            exp_b = pending.pop_front();
            if (got.placed !== exp_b.placed) begin
                $error("placed: expected %0d actual %0d", exp_b.placed, got.placed);
                errors++;
            end
            if (got.assigned_slot !== exp_b.assigned_slot) begin
                $error("assigned_slot: expected %0d actual %0d",
                       exp_b.assigned_slot, got.assigned_slot);
                errors++;
            end
            if (got.assigned_room !== exp_b.assigned_room) begin
                $error("assigned_room: expected %0d actual %0d",
                       exp_b.assigned_room, got.assigned_room);
                errors++;
            end
            if (got.highest_used_slot !== exp_b.highest_used_slot) begin
                $error("highest_used_slot: expected %0d actual %0d",
                       exp_b.highest_used_slot, got.highest_used_slot);
                errors++;
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    ffrs_pkg::in_beat_t             s_data;
    logic                           m_valid;
    logic                           m_ready;
    ffrs_pkg::out_beat_t            m_data;
    logic                           cfg_we;
    logic                           cfg_index;
    logic [ffrs_pkg::CFG_WIDTH-1:0] cfg_wdata;

    placement_board board;
    bit   calm;
    int   cycles;
    int   beats_in;

    first_fit_room_slot_assigner u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("first_fit_room_slot_assigner: mismatch");
            $finish;
        end
    end

    // result side: random stalls, check at the rising edge
    always @(negedge aclk) begin
        if (aresetn) m_ready = calm || ($urandom_range(99) >= 35);
    end
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check(m_data);
    end

    // push one input beat, with a random gap before it
    task automatic send_beat(ffrs_pkg::in_beat_t b);
        @(negedge aclk);
        if (!calm && $urandom_range(99) < 35) begin
            s_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = b;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        board.note_input(b);
        beats_in++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, bit [10:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        board.set_reg(idx, val);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic ffrs_pkg::in_beat_t make_beat(logic [1:0] f, int c, int p, int rm,
                                                     int amt);
        ffrs_pkg::in_beat_t b;
        b.func           = f;
        b.course_id      = 10'(c);
        b.partner_course = 10'(p);
        b.room_index     = 4'(rm);
        b.amount         = 16'(amt);
        return b;
    endfunction

    // mostly a small course pool so conflicts bite, sometimes the full range
    function automatic int pick_course();
        return ($urandom_range(99) < 80) ? $urandom_range(15) : $urandom_range(N_COURSES - 1);
    endfunction

    function automatic ffrs_pkg::in_beat_t random_beat();
        ffrs_pkg::in_beat_t b;
        int roll;
        b = '0;
        b.room_index     = 4'($urandom_range(15));
        b.course_id      = 10'(pick_course());
        b.partner_course = 10'(pick_course());
        roll = $urandom_range(99);
        if (roll < 3) b.func = ffrs_pkg::FUNC_BEGIN;
        else if (roll < 15) b.func = ffrs_pkg::FUNC_SET_CAP;
        else if (roll < 40) b.func = ffrs_pkg::FUNC_ADD_PAIR;
        else b.func = ffrs_pkg::FUNC_PLACE;
        roll = $urandom_range(99);
        if (roll < 80) b.amount = 16'($urandom_range(400));
        else if (roll < 88) b.amount = 16'h0000;
        else if (roll < 94) b.amount = 16'hffff;
        else b.amount = 16'($urandom);
        return b;
    endfunction

    // register settings of the random phases: rooms, slots
    int phase_rooms [6] = '{1, 4, 16, 0, 31, 2};
    int phase_slots [6] = '{1, 8, 4, 3, 2047, 16};

    initial begin
        board     = new();
        calm      = 1'b0;
        cycles    = 0;
        beats_in  = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = ffrs_pkg::CFG_NUM_ROOMS;
        cfg_wdata = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part at the widest search
        write_reg(ffrs_pkg::CFG_NUM_ROOMS, 11'd16);
        write_reg(ffrs_pkg::CFG_SLOT_CAP, 11'd1024);
        for (int rm = 0; rm < N_ROOMS; rm++)
            send_beat(make_beat(ffrs_pkg::FUNC_SET_CAP, 0, 0, rm,
                                (rm == 15) ? 16'hffff : (rm == 0 ? 0 : rm * 100)));
        send_beat(make_beat(ffrs_pkg::FUNC_ADD_PAIR, 0, 1023, 0, 0));
        send_beat(make_beat(ffrs_pkg::FUNC_ADD_PAIR, 5, 5, 15, 16'hffff));
        send_beat(make_beat(ffrs_pkg::FUNC_PLACE, 5, 0, 0, 0));
        // self conflict: second placement avoids the slot that holds it
        send_beat(make_beat(ffrs_pkg::FUNC_PLACE, 5, 1023, 15, 0));
        send_beat(make_beat(ffrs_pkg::FUNC_PLACE, 1023, 0, 0, 16'hffff));
        send_beat(make_beat(ffrs_pkg::FUNC_PLACE, 0, 0, 0, 16'hffff));
        // course placed twice without conflict
        send_beat(make_beat(ffrs_pkg::FUNC_PLACE, 7, 0, 0, 150));
        send_beat(make_beat(ffrs_pkg::FUNC_PLACE, 7, 0, 0, 150));
        send_beat(make_beat(ffrs_pkg::FUNC_BEGIN, 1023, 1023, 15, 16'hffff));
        drain();

        // random phases, one no-idle stretch in the middle
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ffrs_pkg::CFG_NUM_ROOMS, 11'(phase_rooms[ph]));
            write_reg(ffrs_pkg::CFG_SLOT_CAP, 11'(phase_slots[ph]));
            calm = (ph == 2);
            for (int i = 0; i < 19; i++) begin
                if (ph == 1 && i == 11) drain();
                send_beat(random_beat());
            end
            drain();
        end
        calm = 1'b0;

        $display("ran %0d input beats over 7 register settings", beats_in);
        $display("placements: %0d placed, %0d found no room or slot",
                 board.placed_cnt, board.failed_cnt);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("first_fit_room_slot_assigner: match");
        end else begin
            $display("first_fit_room_slot_assigner: mismatch");
        end
        $finish;
    end
endmodule

[sim.f]
hdl/ffrs_pkg.sv
hdl/first_fit_room_slot_assigner.sv
hdl/ffrs_checker.sv
tb/tb_first_fit_room_slot_assigner.sv
